// File: hw/rtl/rid_pkg.sv
`default_nettype none

package rid_pkg;

  // Operation codes carried in the opcode field of a request.
  typedef enum logic [1:0] {
    OP_DIVU32 = 2'd0,
    OP_DIVS32 = 2'd1,
    OP_DIVU64 = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CntW  = 7;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/restoring_integer_divider.sv
// Sequence: an accepted request moves the sequencer from ST_IDLE to ST_RUN, which produces
// the quotient bits, then to ST_FIN, which writes the output register once it is free;
// an undefined opcode skips ST_RUN. A new request is taken only in ST_IDLE. One shared
// 65-bit subtract and compare produces one quotient bit per cycle. A finished result waits
// in the output register while the next request is taken. Reset (rst_ni, asynchronous,
// active low) empties the output register and returns the sequencer to idle.
`default_nettype none

module restoring_integer_divider
  import rid_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] nq_q, nq_d;
  logic [DataW-1:0] div_q, div_d;
  logic             signed_q, signed_d;
  logic             negq_q, negq_d;
  logic             negr_q, negr_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  // Operand decode for the signed mode.
  logic [HalfW-1:0] a_lo, b_lo, mag_a, mag_b;
  logic             sign_a, sign_b;

  assign a_lo   = in_data_i.dividend[HalfW-1:0];
  assign b_lo   = in_data_i.divisor[HalfW-1:0];
  assign sign_a = a_lo[HalfW-1];
  assign sign_b = b_lo[HalfW-1];
  assign mag_a  = sign_a ? (HalfW'(0) - a_lo) : a_lo;
  assign mag_b  = sign_b ? (HalfW'(0) - b_lo) : b_lo;

  // Shared shift-and-subtract step: one quotient bit per cycle.
  logic [DataW:0]   rem_shift;
  logic [DataW+1:0] diff;
  logic             ge;

  assign rem_shift = {rem_q, nq_q[DataW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, div_q};
  assign ge        = ~diff[DataW+1];

  // Final sign fix-up for the signed mode.
  logic [HalfW-1:0] q_lo, r_lo, q_fix, r_fix;

  assign q_lo  = nq_q[HalfW-1:0];
  assign r_lo  = rem_q[HalfW-1:0];
  assign q_fix = negq_q ? (HalfW'(0) - q_lo) : q_lo;
  assign r_fix = negr_q ? (HalfW'(0) - r_lo) : r_lo;

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    nq_q     <= nq_d;
    div_q    <= div_d;
    signed_q <= signed_d;
    negq_q   <= negq_d;
    negr_q   <= negr_d;
    out_q    <= out_d;
  end

  // Sequencer and datapath control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    nq_d        = nq_q;
    div_d       = div_q;
    signed_d    = signed_q;
    negq_d      = negq_q;
    negr_d      = negr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rem_d    = '0;
          signed_d = 1'b0;
          negq_d   = 1'b0;
          negr_d   = 1'b0;
          state_d  = ST_RUN;
          if (in_data_i.opcode == OP_DIVU32) begin
            nq_d  = {a_lo, {HalfW{1'b0}}};
            div_d = {{HalfW{1'b0}}, b_lo};
            cnt_d = CntW'(HalfW);
          end else if (in_data_i.opcode == OP_DIVS32) begin
            nq_d     = {mag_a, {HalfW{1'b0}}};
            div_d    = {{HalfW{1'b0}}, mag_b};
            cnt_d    = CntW'(HalfW);
            // A zero divisor leaves the magnitudes unsigned.
            signed_d = (mag_b != '0);
            negq_d   = sign_a ^ sign_b;
            negr_d   = sign_a;
          end else if (in_data_i.opcode == OP_DIVU64) begin
            nq_d  = in_data_i.dividend;
            div_d = in_data_i.divisor;
            cnt_d = CntW'(DataW);
          end else begin
            // Undefined opcode: skip straight to an all-zero result.
            nq_d    = '0;
            state_d = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        rem_d = ge ? diff[DataW-1:0] : rem_shift[DataW-1:0];
        nq_d  = {nq_q[DataW-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (signed_q) begin
            out_d.quotient  = {{HalfW{1'b0}}, q_fix};
            out_d.remainder = {{HalfW{1'b0}}, r_fix};
          end else begin
            out_d.quotient  = nq_q;
            out_d.remainder = rem_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/rid_checker.sv
`default_nettype none

module rid_checker
  import rid_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire req_t in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire rsp_t out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The divider takes no new request right after accepting one.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while busy");

  // An undefined opcode accepted while the output is empty returns zeros through ST_FIN.
  a_bad_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (in_data_i.opcode == 2'd3) |-> ##2
      (out_valid_o && (out_data_o.quotient == '0) && (out_data_o.remainder == '0)))
    else $error("undefined opcode gave a nonzero result");

  // Unsigned 32-bit division by zero gives an all-ones 32-bit quotient.
  a_div0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (in_data_i.opcode == OP_DIVU32)
      && (in_data_i.divisor[HalfW-1:0] == '0) |-> ##34
      (out_valid_o && (out_data_o.quotient == {{HalfW{1'b0}}, {HalfW{1'b1}}})))
    else $error("wrong quotient on zero divisor");

endmodule

bind restoring_integer_divider rid_checker u_rid_checker (.*);

`default_nettype wire

// File: tb/restoring_integer_divider_tb.sv
`timescale 1ns / 1ps

module restoring_integer_divider_tb;
  import rid_pkg::*;

  // Opcode value with no defined operation; the block answers it with zeros.
  localparam logic [1:0] OpUndef = 2'd3;

  localparam int unsigned RandPerPhase = 250;
  localparam int unsigned DrainCycles  = 80;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned NumDirected  = 22;

  localparam logic [63:0] AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Ones32   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] IntMin32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] Top64    = 64'h8000_0000_0000_0000;

  // One row of the directed table. Where known is set, quo and rem are the
  // expected result; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] num;
    logic [63:0] den;
    logic        known;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_vec_t;

  div_vec_t directed_vecs [NumDirected] = '{
    '{OP_DIVU32, 64'd100, 64'd7, 1'b0, 64'd0, 64'd0},
    '{OP_DIVU32, Ones32, 64'd1, 1'b1, Ones32, 64'd0},
    '{OP_DIVU32, 64'd5, 64'd0, 1'b1, Ones32, 64'd5},
    '{OP_DIVU32, 64'hDEAD_BEEF_0000_0064, 64'h1234_5678_0000_0007, 1'b0, 64'd0, 64'd0},
    '{OP_DIVU32, 64'd0, Ones32, 1'b1, 64'd0, 64'd0},
    '{OP_DIVU32, AllOnes, AllOnes, 1'b1, 64'd1, 64'd0},
    '{OP_DIVS32, 64'hFFFF_FFF9, 64'd2, 1'b0, 64'd0, 64'd0},
    '{OP_DIVS32, 64'd7, 64'hFFFF_FFFE, 1'b0, 64'd0, 64'd0},
    '{OP_DIVS32, 64'hFFFF_FFF9, 64'hFFFF_FFFE, 1'b0, 64'd0, 64'd0},
    '{OP_DIVS32, IntMin32, Ones32, 1'b1, IntMin32, 64'd0},
    '{OP_DIVS32, IntMin32, 64'd1, 1'b1, IntMin32, 64'd0},
    '{OP_DIVS32, IntMin32, 64'd0, 1'b1, Ones32, IntMin32},
    '{OP_DIVS32, 64'hFFFF_FFFB, 64'd0, 1'b1, Ones32, 64'd5},
    '{OP_DIVS32, 64'h7FFF_FFFF, Ones32, 1'b0, 64'd0, 64'd0},
    '{OP_DIVS32, IntMin32, IntMin32, 1'b0, 64'd0, 64'd0},
    '{OP_DIVU64, AllOnes, 64'd1, 1'b1, AllOnes, 64'd0},
    '{OP_DIVU64, AllOnes, AllOnes, 1'b1, 64'd1, 64'd0},
    '{OP_DIVU64, AllOnes, 64'd0, 1'b1, AllOnes, AllOnes},
    '{OP_DIVU64, Top64, 64'd3, 1'b0, 64'd0, 64'd0},
    '{OP_DIVU64, 64'h1234_5678_9ABC_DEF0, 64'h0000_0001_0000_0001, 1'b0, 64'd0, 64'd0},
    '{OP_DIVU64, 64'd1, Top64, 1'b1, 64'd0, 64'd1},
    '{OpUndef, AllOnes, 64'd3, 1'b1, 64'd0, 64'd0}
  };

  // Idle and stall percentages for each phase of the random part.
  int unsigned send_pct_by_phase [4] = '{0, 49, 0, 14};
  int unsigned stall_pct_by_phase [4] = '{0, 0, 49, 14};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  rsp_t        expected_divs [$];
  rsp_t        oldest_div;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  restoring_integer_divider dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shift-and-subtract over the low width bits of num. A 65-bit partial
  // remainder keeps the bit that falls off the top during the shift.
  function automatic void shift_subtract(input logic [63:0] num, input logic [63:0] den,
                                         input int width, output logic [63:0] quo,
                                         output logic [63:0] rem);
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int i = width - 1; i >= 0; i--) begin
      part = {part[63:0], num[i]};
      quo  = quo << 1;
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    rem = part[63:0];
  endfunction

  // Quotient and remainder that the block must return for one request.
  function automatic rsp_t divide_request(input req_t r);
    rsp_t        res;
    logic [31:0] a, b, mag_a, mag_b, q32, r32;
    logic        neg_a, neg_b;
    logic [63:0] quo, rem;
    res = '0;
    case (r.opcode)
      OP_DIVU32: begin
        shift_subtract({32'd0, r.dividend[31:0]}, {32'd0, r.divisor[31:0]}, 32, quo, rem);
        res.quotient  = quo;
        res.remainder = rem;
      end
      OP_DIVS32: begin
        a     = r.dividend[31:0];
        b     = r.divisor[31:0];
        neg_a = a[31];
        neg_b = b[31];
        mag_a = neg_a ? -a : a;
        mag_b = neg_b ? -b : b;
        shift_subtract({32'd0, mag_a}, {32'd0, mag_b}, 32, quo, rem);
        // A zero divisor leaves the magnitudes untouched by the signs.
        if (mag_b != 32'd0) begin
          q32 = quo[31:0];
          r32 = rem[31:0];
          if (neg_a != neg_b) q32 = -q32;
          if (neg_a) r32 = -r32;
          quo = {32'd0, q32};
          rem = {32'd0, r32};
        end
        res.quotient  = quo;
        res.remainder = rem;
      end
      OP_DIVU64: begin
        shift_subtract(r.dividend, r.divisor, 64, quo, rem);
        res.quotient  = quo;
        res.remainder = rem;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Operand mix: zeros, ones, sign boundaries, narrow and negative values,
  // and plain random bits.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = 64'd0;
      1: v = 64'd1;
      2: v = AllOnes;
      3: v = {v[63:32], 32'h8000_0000};
      4: v = Top64;
      5, 6: v = v >> $urandom_range(63);
      7: v = -(v >> $urandom_range(63));
      default: ;
    endcase
    return v;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick < 5) r.opcode = OP_DIVU32;
    else if (pick < 10) r.opcode = OP_DIVS32;
    else if (pick < 15) r.opcode = OP_DIVU64;
    else r.opcode = OpUndef;
    r.dividend = rand_operand();
    r.divisor  = rand_operand();
    return r;
  endfunction

  // Present one request and hold it until accepted. Valid drops only when
  // an idle gap is taken, so it is never lowered and raised in one step.
  task automatic send_request(input req_t r, input rsp_t want);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_divs.push_back(want);
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Compare each returned result with the oldest outstanding one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_divs.size() == 0) begin
        $error("unexpected result: quotient %h remainder %h",
               out_data_o.quotient, out_data_o.remainder);
        error_count++;
      end else begin
        oldest_div = expected_divs.pop_front();
        if (out_data_o.quotient !== oldest_div.quotient) begin
          $error("quotient: expected %h, got %h", oldest_div.quotient, out_data_o.quotient);
          error_count++;
        end
        if (out_data_o.remainder !== oldest_div.remainder) begin
          $error("remainder: expected %h, got %h", oldest_div.remainder,
                 out_data_o.remainder);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    req_t r;
    rsp_t want;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, without idling.
    for (int i = 0; i < NumDirected; i++) begin
      r.opcode   = directed_vecs[i].op;
      r.dividend = directed_vecs[i].num;
      r.divisor  = directed_vecs[i].den;
      if (directed_vecs[i].known) begin
        want.quotient  = directed_vecs[i].quo;
        want.remainder = directed_vecs[i].rem;
      end else begin
        want = divide_request(r);
      end
      send_request(r, want);
    end

    // Random requests under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct_by_phase[p];
      stall_pct     = stall_pct_by_phase[p];
      for (int i = 0; i < RandPerPhase; i++) begin
        r = rand_request();
        send_request(r, divide_request(r));
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then watch for strays.
    while (expected_divs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
